/* rtl/mmpr_pkg.sv */
// Shared types, constants and the CRC helper for the meter poll receiver.
`default_nettype none

package mmpr_pkg;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_TICK    = 2'd1,
        OP_POLL    = 2'd2
    } op_t;

    // Result kinds; KIND_TX doubles as the "send the query burst" command.
    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_READING = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    // Command passed from the front end to the back end.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] power1;
        logic [31:0] power2;
    } cmd_t;

    // Status of the command queue as seen by the front end.
    typedef struct packed {
        logic full;
        logic empty;
    } cmdq_status_t;

    localparam int FRAME_BYTES_DEFAULT = 33;
    localparam int CMD_DEPTH_DEFAULT   = 4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd150;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;
    localparam logic [7:0]  ADDR_BYTE     = 8'h01;

    // Frame byte positions of the two big-endian power words.
    localparam int P1_FIRST = 7;
    localparam int P1_LAST  = 10;
    localparam int P2_FIRST = 23;
    localparam int P2_LAST  = 26;

    localparam logic [2:0] QUERY_LAST_IDX = 3'd7;

    // Fixed read query: holding registers 0x48..0x55 of unit 1, with CRC.
    function automatic logic [7:0] query_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h01;
            3'd1:    b = 8'h03;
            3'd2:    b = 8'h00;
            3'd3:    b = 8'h48;
            3'd4:    b = 8'h00;
            3'd5:    b = 8'h0E;
            3'd6:    b = 8'h44;
            default: b = 8'h18;
        endcase
        return b;
    endfunction

    // One byte of CRC-16/Modbus, reflected, eight shift steps.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/mmpr_cmd_fifo.sv */
// Short command queue between the front end and the back end.
`default_nettype none

module mmpr_cmd_fifo #(
    parameter int DEPTH = mmpr_pkg::CMD_DEPTH_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  wire mmpr_pkg::cmd_t  wr_data,
    input  wire                  rd_en,
    output mmpr_pkg::cmd_t       rd_data,
    output mmpr_pkg::cmdq_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mmpr_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_wr, do_rd;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/mmpr_front.sv */
// Front end: takes input transactions, tracks the poll state and frame, emits commands.
`default_nettype none

module mmpr_front #(
    parameter int FRAME_BYTES = mmpr_pkg::FRAME_BYTES_DEFAULT
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire  [15:0]            cfg_wdata,
    input  wire                    in_push,
    input  wire  [1:0]             in_op,
    input  wire  [7:0]             in_byte,
    input  wire mmpr_pkg::cmdq_status_t q_status,
    output logic                   cmd_push,
    output mmpr_pkg::cmd_t         cmd
);

    localparam int CNT_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CRC_LO_IDX = CNT_W'(FRAME_BYTES - 2);
    localparam logic [CNT_W-1:0] P1_LO      = CNT_W'(mmpr_pkg::P1_FIRST);
    localparam logic [CNT_W-1:0] P1_HI      = CNT_W'(mmpr_pkg::P1_LAST);
    localparam logic [CNT_W-1:0] P2_LO      = CNT_W'(mmpr_pkg::P2_FIRST);
    localparam logic [CNT_W-1:0] P2_HI      = CNT_W'(mmpr_pkg::P2_LAST);

    logic [15:0]      timeout_reg;
    logic             waiting_reg, waiting_next;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic [31:0]      p1_reg, p1_next;
    logic [31:0]      p2_reg, p2_next;

    logic        accept;
    logic [15:0] elapsed_inc;
    logic        clear;

    assign accept = in_push && !q_status.full;
    assign elapsed_inc = (elapsed_reg == mmpr_pkg::ELAPSED_MAX) ? elapsed_reg
                                                               : elapsed_reg + 16'd1;

    always_comb
    begin
        waiting_next = waiting_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        crc_lo_next  = crc_lo_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        clear        = 1'b0;
        cmd_push     = 1'b0;
        cmd.kind     = mmpr_pkg::KIND_TX;
        cmd.power1   = '0;
        cmd.power2   = '0;

        if (accept)
        begin
            unique case (in_op)
                mmpr_pkg::OP_POLL:
                begin
                    if (!waiting_reg)
                    begin
                        cmd_push     = 1'b1;
                        cmd.kind     = mmpr_pkg::KIND_TX;
                        waiting_next = 1'b1;
                        elapsed_next = '0;
                        clear        = 1'b1;
                    end
                end
                mmpr_pkg::OP_TICK:
                begin
                    if (waiting_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc > timeout_reg)
                        begin
                            cmd_push     = 1'b1;
                            cmd.kind     = mmpr_pkg::KIND_TIMEOUT;
                            waiting_next = 1'b0;
                            clear        = 1'b1;
                        end
                    end
                end
                mmpr_pkg::OP_RX_BYTE:
                begin
                    if (waiting_reg && !(count_reg == '0 && in_byte != mmpr_pkg::ADDR_BYTE))
                    begin
                        if (count_reg < CRC_LO_IDX)
                        begin
                            crc_next   = mmpr_pkg::crc16_byte(crc_reg, in_byte);
                            count_next = count_reg + 1'b1;
                            if (count_reg >= P1_LO && count_reg <= P1_HI)
                            begin
                                p1_next = {p1_reg[23:0], in_byte};
                            end
                            if (count_reg >= P2_LO && count_reg <= P2_HI)
                            begin
                                p2_next = {p2_reg[23:0], in_byte};
                            end
                        end
                        else if (count_reg == CRC_LO_IDX)
                        begin
                            crc_lo_next = in_byte;
                            count_next  = count_reg + 1'b1;
                        end
                        else
                        begin
                            // Last byte: high half of the wire CRC closes the frame.
                            cmd_push = 1'b1;
                            if ({in_byte, crc_lo_reg} == crc_reg)
                            begin
                                cmd.kind   = mmpr_pkg::KIND_READING;
                                cmd.power1 = p1_reg;
                                cmd.power2 = p2_reg;
                            end
                            else
                            begin
                                cmd.kind = mmpr_pkg::KIND_CRC_ERR;
                            end
                            waiting_next = 1'b0;
                            clear        = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (clear)
        begin
            count_next  = '0;
            crc_next    = mmpr_pkg::CRC_INIT;
            crc_lo_next = '0;
            p1_next     = '0;
            p2_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= mmpr_pkg::TIMEOUT_RESET;
            waiting_reg <= 1'b0;
            elapsed_reg <= '0;
            count_reg   <= '0;
            crc_reg     <= mmpr_pkg::CRC_INIT;
            crc_lo_reg  <= '0;
            p1_reg      <= '0;
            p2_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            waiting_reg <= waiting_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            crc_lo_reg  <= crc_lo_next;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mmpr_back.sv */
// Back end: expands commands into result transactions held in an output register.
`default_nettype none

module mmpr_back (
    input  wire            clk,
    input  wire            rst_n,
    input  wire mmpr_pkg::cmd_t cmd,
    input  wire            cmd_empty,
    output logic           cmd_pop,
    input  wire            pop,
    output logic           empty,
    output logic [1:0]     kind,
    output logic [7:0]     tx_byte,
    output logic [31:0]    power1_raw,
    output logic [31:0]    power2_raw,
    output logic           last
);

    logic           out_valid_reg, out_valid_next;
    mmpr_pkg::kind_t kind_reg;
    logic [7:0]     tx_reg;
    logic [31:0]    p1_reg, p2_reg;
    logic           last_reg;
    logic [2:0]     idx_reg, idx_next;

    logic load;
    logic is_tx;
    logic is_reading;
    logic burst_end;

    assign load       = !cmd_empty && (!out_valid_reg || pop);
    assign is_tx      = (cmd.kind == mmpr_pkg::KIND_TX);
    assign is_reading = (cmd.kind == mmpr_pkg::KIND_READING);
    assign burst_end  = (idx_reg == mmpr_pkg::QUERY_LAST_IDX);
    assign cmd_pop    = load && (!is_tx || burst_end);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (is_tx)
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= cmd.kind;
            tx_reg   <= is_tx ? mmpr_pkg::query_byte(idx_reg) : 8'h00;
            p1_reg   <= is_reading ? cmd.power1 : 32'h0;
            p2_reg   <= is_reading ? cmd.power2 : 32'h0;
            last_reg <= !is_tx || burst_end;
        end
    end

    assign empty      = !out_valid_reg;
    assign kind       = kind_reg;
    assign tx_byte    = tx_reg;
    assign power1_raw = p1_reg;
    assign power2_raw = p2_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

/* rtl/modbus_meter_poll_receiver_unit.sv */
// Top level of the Modbus RTU meter poll receiver: front end, command queue, back end.
`default_nettype none

// The block polls a meter over Modbus RTU. An input transaction carries op
// (0 received byte, 1 millisecond tick, 2 poll request) and rx_byte. A poll
// while idle produces eight result transactions of kind 0 with the fixed read
// query in tx_byte, the last one flagged by last, and starts a wait. During the
// wait, bytes are ignored until the address byte 0x01, which opens a frame of
// FRAME_BYTES bytes checked with CRC-16/Modbus (low CRC byte first on the wire).
// The frame ends in one result: kind 1 with the two big-endian powers in units
// of 0.0001 W, or kind 2 on a CRC mismatch. Ticks that push the elapsed count
// past timeout_ms end the wait with a kind 3 result. Unused fields are zero.
// Timing: the front end handles one input transaction per cycle while full is low;
// each one that produces results leaves a command in a CMD_DEPTH-entry queue. The
// back end drains one result per cycle, while results are popped, through its output
// register, so a poll occupies it for one result per query byte (stepped by its byte
// counter) and every other command for one result. full rises only while the
// command queue holds CMD_DEPTH commands; results pass through the queue and the
// output register. The user must write timeout_ms through cfg_we and cfg_wdata only
// while the block is idle (the block does not enforce this); it resets to 150.
module modbus_meter_poll_receiver_unit #(
    parameter int FRAME_BYTES = mmpr_pkg::FRAME_BYTES_DEFAULT,
    parameter int CMD_DEPTH   = mmpr_pkg::CMD_DEPTH_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [15:0] cfg_wdata,
    input  wire         push,
    output logic        full,
    input  wire  [1:0]  op,
    input  wire  [7:0]  rx_byte,
    output logic        empty,
    input  wire         pop,
    output logic [1:0]  kind,
    output logic [7:0]  tx_byte,
    output logic [31:0] power1_raw,
    output logic [31:0] power2_raw,
    output logic        last
);

    mmpr_pkg::cmdq_status_t q_status;
    mmpr_pkg::cmd_t         front_cmd;
    mmpr_pkg::cmd_t         back_cmd;
    logic                   cmd_push;
    logic                   cmd_pop;

    // The front end sees every transaction the queue has room for.
    assign full = q_status.full;

    mmpr_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_push  (push),
        .in_op    (op),
        .in_byte  (rx_byte),
        .q_status (q_status),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    mmpr_cmd_fifo #(
        .DEPTH(CMD_DEPTH)
    ) u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_data(front_cmd),
        .rd_en  (cmd_pop),
        .rd_data(back_cmd),
        .status (q_status)
    );

    mmpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (q_status.empty),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .kind      (kind),
        .tx_byte   (tx_byte),
        .power1_raw(power1_raw),
        .power2_raw(power2_raw),
        .last      (last)
    );

    // A command is only produced for a transaction the queue had room for.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !q_status.full)
        else $error("command pushed into a full queue");

    // The back end never pulls from an empty queue.
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !q_status.empty)
        else $error("command popped from an empty queue");

    // Status and reading results are always single and final.
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != mmpr_pkg::KIND_TX) |-> last)
        else $error("non-query result without last");

    // Powers are zero on every result that is not a reading.
    a_power_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != mmpr_pkg::KIND_READING) |->
            (power1_raw == 32'h0 && power2_raw == 32'h0))
        else $error("power fields set outside a reading");

endmodule

`default_nettype wire
